// File: rtl/eist_pkg.sv
package eist_pkg;

	localparam int SLOTS_DEF = 8;

	localparam logic [7:0] PIN_FIRST = 8'd100;
	localparam logic [7:0] PIN_LAST  = 8'd115;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_ATTACH = 2'd1;
	localparam logic [1:0] OP_DETACH = 2'd2;

	localparam logic [1:0] MODE_RISE = 2'd0;
	localparam logic [1:0] MODE_FALL = 2'd1;
	localparam logic [1:0] MODE_ANY  = 2'd2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_MISSING = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  pin;
		logic [1:0]  edge_mode;
		logic        initial_level;
		logic [15:0] pin_levels;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] slot_index;
		logic [7:0] fired_mask;
	} rsp_t;

	typedef struct packed {
		logic [7:0] pin;
		logic [1:0] mode;
		logic       level;
	} slot_entry_t;

endpackage

// File: rtl/edge_interrupt_slot_table_core.sv
// channel   signals           transaction
// request   start, busy, req  accepted at a rising edge with start high and busy low
// response  done, rsp         valid for the single cycle that done is high
//
// A transaction walks the slot table in order, one slot per cycle through the
// entry RAM (one read port, one write port, registered read data).
// done is registered from the evaluation of the last slot and busy falls with
// it; a new transaction is accepted once busy is low. Attach and detach finish
// early at the slot they hit, with done registered from that slot's evaluation.
// arst_n clears the enable flags and the sequencer; the RAM is not cleared.
// The response cannot be stalled: done pulses once per transaction.
module edge_interrupt_slot_table_core
	import eist_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int MW = $bits(slot_entry_t);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic              state_q;
	req_t              item_q;
	logic [CW-1:0]     cnt_q;
	logic              v_s1;
	logic [IW-1:0]     idx_s1;
	logic [MW-1:0]     rdata_s1;
	logic [SLOTS-1:0]  en_q;
	logic [7:0]        fired_q;
	logic              done_q;
	rsp_t              rsp_q;

	logic [MW-1:0] mem [SLOTS];

	slot_entry_t   ent;
	slot_entry_t   wd;
	logic          we;
	logic          re;
	logic          hit;
	logic          fire;
	logic          slot_en;
	logic          in_range;
	logic          now_lvl;
	logic [7:0]    off;
	logic          last;
	logic          finish;
	logic [IW+2:0] idx_ext;
	logic [7:0]    fire_bit;
	logic [1:0]    miss_status;

	assign busy = (state_q == ST_RUN);
	assign done = done_q;
	assign rsp  = rsp_q;

	assign ent      = slot_entry_t'(rdata_s1);
	assign slot_en  = en_q[idx_s1];
	assign in_range = (ent.pin >= PIN_FIRST) && (ent.pin <= PIN_LAST);
	assign off      = ent.pin - PIN_FIRST;
	assign now_lvl  = item_q.pin_levels[off[3:0]];
	assign idx_ext  = {3'b000, idx_s1};
	assign last     = (idx_s1 == IW'(SLOTS - 1));
	assign re       = busy && (cnt_q < CW'(SLOTS));

	always_comb begin
		we   = 1'b0;
		wd   = ent;
		hit  = 1'b0;
		fire = 1'b0;
		if (busy && v_s1) begin
			case (item_q.op)
				OP_SAMPLE: begin
					if (slot_en && in_range) begin
						case (ent.mode)
							MODE_RISE: fire = !ent.level && now_lvl;
							MODE_FALL: fire = ent.level && !now_lvl;
							MODE_ANY:  fire = ent.level != now_lvl;
							default:   fire = 1'b0;
						endcase
						we       = 1'b1;
						wd.level = now_lvl;
					end
				end
				OP_ATTACH: begin
					if (!slot_en) begin
						we  = 1'b1;
						wd  = '{pin: item_q.pin, mode: item_q.edge_mode,
							level: item_q.initial_level};
						hit = 1'b1;
					end
				end
				OP_DETACH: begin
					hit = slot_en && (ent.pin == item_q.pin);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		fire_bit = 8'h00;
		// slots past the eighth have no bit in the mask
		if (fire && (idx_ext[IW+2:3] == '0)) begin
			fire_bit[idx_ext[2:0]] = 1'b1;
		end
	end

	always_comb begin
		case (item_q.op)
			OP_ATTACH: miss_status = STATUS_FULL;
			OP_DETACH: miss_status = STATUS_MISSING;
			default:   miss_status = STATUS_OK;
		endcase
	end

	assign finish = busy && v_s1 && (hit || last);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[idx_s1] <= MW'(wd);
		end
		if (re) begin
			rdata_s1 <= mem[cnt_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			en_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= finish;
			case (state_q)
				ST_IDLE: begin
					v_s1 <= 1'b0;
					if (start) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					v_s1 <= re && !finish;
					if (re) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (hit) begin
						en_q[idx_s1] <= (item_q.op == OP_ATTACH);
					end
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (!busy && start) begin
			item_q  <= req;
			fired_q <= 8'h00;
		end
		if (re) begin
			idx_s1 <= cnt_q[IW-1:0];
		end
		if (busy && v_s1) begin
			fired_q <= fired_q | fire_bit;
		end
		if (finish) begin
			rsp_q.status     <= hit ? STATUS_OK : miss_status;
			rsp_q.slot_index <= hit ? idx_ext[2:0] : 3'd0;
			rsp_q.fired_mask <= (item_q.op == OP_SAMPLE) ? (fired_q | fire_bit) : 8'h00;
		end
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("done without a preceding busy transaction");

	a_mask_only_sample: assert property (@(posedge clk) disable iff (!arst_n)
		done && (item_q.op != OP_SAMPLE) |-> rsp.fired_mask == 8'h00)
		else $error("fired mask set outside a sample");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == STATUS_FULL) |-> &en_q)
		else $error("full reported with a free slot");

	a_one_read_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !v_s1)
		else $error("slot evaluation outside a transaction");

endmodule
